[rtl/sct_pkg.sv]
// shared types and constants of the script character tokenizer
`timescale 1ns / 1ps

package sct_pkg;

    // configuration register indexes
    localparam logic CFG_FILENAME_MODE = 1'b0;
    localparam logic CFG_COMMA_SEP     = 1'b1;

    // character codes
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TILDE  = 8'h7e;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2a;
    localparam logic [7:0] CH_PLUS   = 8'h2b;
    localparam logic [7:0] CH_COMMA  = 8'h2c;
    localparam logic [7:0] CH_MINUS  = 8'h2d;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_LBRACE = 8'h7b;
    localparam logic [7:0] CH_RBRACE = 8'h7d;

    // one result without its last-of-run flag
    typedef struct packed {
        logic [7:0] token_char;
        logic       has_char;
        logic       ends_token;
        logic       new_line;
    } t_result;

    // queue entry: all results of one input item
    typedef struct packed {
        t_result first;
        t_result second;
        logic    two;
    } t_entry;

    // queue head as seen by the back end
    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_q_head;

endpackage

[rtl/sct_in_if.sv]
// input character channel
`timescale 1ns / 1ps

interface sct_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;

    modport source (output valid, output in_char, input ready);
    modport sink   (input valid, input in_char, output ready);
endinterface

[rtl/sct_out_if.sv]
// token result channel
`timescale 1ns / 1ps

interface sct_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] token_char;
    logic       has_char;
    logic       ends_token;
    logic       new_line;
    logic       last_of_run;

    modport source (output valid, output token_char, output has_char, output ends_token,
                    output new_line, output last_of_run, input ready);
    modport sink   (input valid, input token_char, input has_char, input ends_token,
                    input new_line, input last_of_run, output ready);
endinterface

[rtl/sct_front.sv]
// front end: accepts characters, classifies them, tracks the token state
`timescale 1ns / 1ps

module sct_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic           i_cfg_idx,
    input  logic           i_cfg_data,
    input  logic           i_full,
    sct_in_if.sink         i_in,
    output logic           o_push,
    output sct_pkg::t_entry o_entry
);

    logic r_filename_mode;
    logic r_comma_sep;
    logic r_inside;
    logic n_inside;
    logic accept;
    logic gen;
    logic [7:0] c;
    sct_pkg::t_result end_plain;
    sct_pkg::t_result end_nl;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && !i_full;
    assign o_push     = accept && gen;
    assign c          = i_in.in_char;

    always_comb begin
        end_plain = '{token_char: 8'h00, has_char: 1'b0, ends_token: 1'b1, new_line: 1'b0};
        end_nl    = '{token_char: 8'h00, has_char: 1'b0, ends_token: 1'b1, new_line: 1'b1};
        o_entry.first  = '{token_char: c, has_char: 1'b1, ends_token: 1'b0, new_line: 1'b0};
        o_entry.second = '{token_char: c, has_char: 1'b1, ends_token: 1'b0, new_line: 1'b0};
        o_entry.two    = 1'b0;
        gen            = 1'b1;
        n_inside       = 1'b1;
        if (c == sct_pkg::CH_NUL) begin
            o_entry.first = end_nl;
            n_inside      = 1'b0;
        end else if (c != sct_pkg::CH_TAB && (c < sct_pkg::CH_SPACE || c > sct_pkg::CH_TILDE)) begin
            // control byte: inside a token also yields an empty newline token
            o_entry.first  = end_nl;
            o_entry.second = end_nl;
            o_entry.two    = r_inside;
            n_inside       = 1'b0;
        end else if (c inside {sct_pkg::CH_SPACE, sct_pkg::CH_TAB, sct_pkg::CH_SQUOTE,
                               sct_pkg::CH_DQUOTE}
                     || (c == sct_pkg::CH_COMMA && r_comma_sep)) begin
            o_entry.first = end_plain;
            gen           = r_inside;
            n_inside      = 1'b0;
        end else if (!r_filename_mode
                     && c inside {sct_pkg::CH_SLASH, sct_pkg::CH_MINUS, sct_pkg::CH_PLUS,
                                  sct_pkg::CH_STAR, sct_pkg::CH_LPAREN, sct_pkg::CH_RPAREN,
                                  sct_pkg::CH_COMMA}) begin
            // one-character operator token
            o_entry.second.ends_token = 1'b1;
            if (r_inside) begin
                o_entry.first = end_plain;
                o_entry.two   = 1'b1;
            end else begin
                o_entry.first.ends_token = 1'b1;
            end
            n_inside = 1'b0;
        end else if ((c == sct_pkg::CH_LBRACE || c == sct_pkg::CH_RBRACE) && r_inside) begin
            o_entry.first = end_plain;
            o_entry.two   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filename_mode <= 1'b0;
            r_comma_sep     <= 1'b0;
            r_inside        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    sct_pkg::CFG_FILENAME_MODE: r_filename_mode <= i_cfg_data;
                    sct_pkg::CFG_COMMA_SEP:     r_comma_sep     <= i_cfg_data;
                    default: ;
                endcase
            end
            if (accept) begin
                r_inside <= n_inside;
            end
        end
    end

endmodule

[rtl/sct_queue.sv]
// small register queue between front and back end
`timescale 1ns / 1ps

module sct_queue #(
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  sct_pkg::t_entry  i_entry,
    input  logic             i_pop,
    output logic             o_full,
    output sct_pkg::t_q_head o_head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    sct_pkg::t_entry r_mem [DEPTH];
    logic [PW-1:0]   r_wr;
    logic [PW-1:0]   r_rd;
    logic [CW-1:0]   r_count;
    logic            do_pop;

    assign o_full       = (r_count == FULL);
    assign o_head.valid = (r_count != '0);
    assign o_head.entry = r_mem[r_rd];
    assign do_pop       = i_pop && o_head.valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LAST) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == LAST) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[rtl/sct_back.sv]
// back end: plays out the results of each queue entry through an output register
`timescale 1ns / 1ps

module sct_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sct_pkg::t_q_head i_head,
    output logic             o_pop,
    sct_out_if.source        o_out
);

    logic             r_phase;
    logic             r_valid;
    sct_pkg::t_result r_res;
    logic             r_last;
    logic             load;

    assign load  = !r_valid || o_out.ready;
    assign o_pop = load && i_head.valid && (r_phase || !i_head.entry.two);

    assign o_out.valid       = r_valid;
    assign o_out.token_char  = r_res.token_char;
    assign o_out.has_char    = r_res.has_char;
    assign o_out.ends_token  = r_res.ends_token;
    assign o_out.new_line    = r_res.new_line;
    assign o_out.last_of_run = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 1'b0;
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_head.valid;
            if (i_head.valid) begin
                r_phase <= !r_phase && i_head.entry.two;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_head.valid) begin
            r_res  <= r_phase ? i_head.entry.second : i_head.entry.first;
            r_last <= r_phase || !i_head.entry.two;
        end
    end

endmodule

[rtl/script_char_tokenizer_unit.sv]
// top level of the script character tokenizer
//
//  channel   dir  signals                                              handshake
//  i_in      in   in_char[7:0]                                         valid/ready
//  o_out     out  token_char[7:0] has_char ends_token new_line last    valid/ready
//  cfg       in   i_cfg_we i_cfg_idx i_cfg_data                        write only
//
// one character is taken per cycle while the queue has room; a character
// yields zero, one or two results, and the back end sends one result per
// cycle from its output register while the receiver is ready, so characters
// with two results limit the sustained input rate once the queue has filled.
// reset (synchronous, active low) empties the queue and clears token state
// and configuration; input and output stall independently through the queue.
`timescale 1ns / 1ps

module script_char_tokenizer_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic      i_cfg_idx,
    input  logic      i_cfg_data,
    sct_in_if.sink    i_in,
    sct_out_if.source o_out
);

    // front to queue
    logic             push;
    sct_pkg::t_entry  entry;
    logic             full;
    // queue to back
    sct_pkg::t_q_head head;
    logic             pop;

    // classifier and token state
    sct_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_full     (full),
        .i_in       (i_in),
        .o_push     (push),
        .o_entry    (entry)
    );

    // decoupling queue, one entry per character that yields results
    sct_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .i_pop   (pop),
        .o_full  (full),
        .o_head  (head)
    );

    // result sequencer and output register
    sct_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

[bench/testbench.sv]
// self-checking bench for the script character tokenizer with its own token predictor
`timescale 1ns / 1ps

module testbench;

    // settle time after the last result, since separators leave nothing to wait for
    localparam int DRAIN_CYCLES   = 10;
    // cycles without any item moving before the run is declared hung
    localparam int WATCHDOG_LIMIT = 1000;
    // length of the long receiver hold-off that backs the block up
    localparam int LONG_HOLD      = 80;
    localparam int PHASE_ITEMS    = 185;

    // one expected or observed result item
    typedef struct packed {
        logic [7:0] token_char;
        logic       has_char;
        logic       ends_token;
        logic       new_line;
        logic       last_of_run;
    } t_tok_result;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_idx;
    logic i_cfg_data;

    sct_in_if  in_if ();
    sct_out_if out_if ();

    script_char_tokenizer_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if.sink),
        .o_out      (out_if.source)
    );

    // script bytes waiting to be offered, and token results still owed by the block
    logic [7:0]  script_bytes[$];
    t_tok_result expected_tokens[$];

    // predictor state: its own copy of the mode registers and the inside-token flag
    logic fname_mode;
    logic comma_sep;
    logic in_token;

    // idling knobs, changed only between phases
    int tx_idle_max;
    int rx_idle_max;
    int tx_wait;
    int rx_wait;
    int hold_reqs;
    int holds_done;
    int errors;
    int stall_cycles;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic void push_token(logic [7:0] ch, logic has, logic ends, logic nl,
                                       logic last);
        t_tok_result r;
        r.token_char  = ch;
        r.has_char    = has;
        r.ends_token  = ends;
        r.new_line    = nl;
        r.last_of_run = last;
        expected_tokens.push_back(r);
    endfunction

    // work out the results one script byte causes and advance the token state
    function automatic void tokenize_char(logic [7:0] c);
        logic is_sep;
        logic is_op;
        is_sep = (c == sct_pkg::CH_SPACE || c == sct_pkg::CH_TAB || c == sct_pkg::CH_SQUOTE
                  || c == sct_pkg::CH_DQUOTE || (c == sct_pkg::CH_COMMA && comma_sep));
        is_op  = !fname_mode && (c == sct_pkg::CH_SLASH || c == sct_pkg::CH_MINUS
                  || c == sct_pkg::CH_PLUS || c == sct_pkg::CH_STAR
                  || c == sct_pkg::CH_LPAREN || c == sct_pkg::CH_RPAREN
                  || c == sct_pkg::CH_COMMA);
        if (c == sct_pkg::CH_NUL) begin
            // string end: close whatever is open, empty or not
            push_token(8'h00, 1'b0, 1'b1, 1'b1, 1'b1);
            in_token = 1'b0;
        end else if (c != sct_pkg::CH_TAB && (c < sct_pkg::CH_SPACE || c > sct_pkg::CH_TILDE)) begin
            // control byte: inside a token it also yields an extra empty line token
            if (in_token) begin
                push_token(8'h00, 1'b0, 1'b1, 1'b1, 1'b0);
                push_token(8'h00, 1'b0, 1'b1, 1'b1, 1'b1);
                in_token = 1'b0;
            end else begin
                push_token(8'h00, 1'b0, 1'b1, 1'b1, 1'b1);
            end
        end else if (is_sep) begin
            // separator only matters when it closes a token
            if (in_token) begin
                push_token(8'h00, 1'b0, 1'b1, 1'b0, 1'b1);
                in_token = 1'b0;
            end
        end else if (is_op) begin
            // operator stands as a token of its own
            if (in_token)
                push_token(8'h00, 1'b0, 1'b1, 1'b0, 1'b0);
            push_token(c, 1'b1, 1'b1, 1'b0, 1'b1);
            in_token = 1'b0;
        end else if ((c == sct_pkg::CH_LBRACE || c == sct_pkg::CH_RBRACE) && in_token) begin
            // brace closes the current token and opens a new one
            push_token(8'h00, 1'b0, 1'b1, 1'b0, 1'b0);
            push_token(c, 1'b1, 1'b0, 1'b0, 1'b1);
            in_token = 1'b1;
        end else begin
            push_token(c, 1'b1, 1'b0, 1'b0, 1'b1);
            in_token = 1'b1;
        end
    endfunction

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    // mostly script-like bytes, with a share of raw noise
    function automatic logic [7:0] pick_script_byte(int noise_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < noise_pct)
            return 8'($urandom_range(0, 255));
        roll = $urandom_range(0, 99);
        if (roll < 45) begin
            return 8'($urandom_range(33, 126));
        end else if (roll < 60) begin
            case ($urandom_range(0, 4))
                0: return sct_pkg::CH_SPACE;
                1: return sct_pkg::CH_TAB;
                2: return sct_pkg::CH_SQUOTE;
                3: return sct_pkg::CH_DQUOTE;
                default: return sct_pkg::CH_COMMA;
            endcase
        end else if (roll < 78) begin
            case ($urandom_range(0, 6))
                0: return sct_pkg::CH_SLASH;
                1: return sct_pkg::CH_MINUS;
                2: return sct_pkg::CH_PLUS;
                3: return sct_pkg::CH_STAR;
                4: return sct_pkg::CH_LPAREN;
                5: return sct_pkg::CH_RPAREN;
                default: return sct_pkg::CH_COMMA;
            endcase
        end else if (roll < 86) begin
            return $urandom_range(0, 1) ? sct_pkg::CH_LBRACE : sct_pkg::CH_RBRACE;
        end else if (roll < 96) begin
            // low control bytes and the high half
            return $urandom_range(0, 1) ? 8'($urandom_range(1, 31))
                                        : 8'($urandom_range(127, 255));
        end
        return sct_pkg::CH_NUL;
    endfunction

    // driver: offers queued script bytes, predicts each accepted item
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            tx_wait = 0;
        end else begin
            if (in_if.valid && in_if.ready)
                tokenize_char(in_if.in_char);
            if (in_if.valid && !in_if.ready) begin
                // keep offering the same item until it is taken
            end else if (tx_wait > 0) begin
                tx_wait--;
                in_if.valid <= 1'b0;
            end else if (script_bytes.size() > 0) begin
                in_if.valid   <= 1'b1;
                in_if.in_char <= script_bytes.pop_front();
                tx_wait = (tx_idle_max > 0) ? $urandom_range(0, tx_idle_max) : 0;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // monitor: checks each result item against the oldest expectation, stalls at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (expected_tokens.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %0h/%b%b%b%b",
                             $time, out_if.token_char, out_if.has_char, out_if.ends_token,
                             out_if.new_line, out_if.last_of_run);
                    errors++;
                end else begin
                    t_tok_result want;
                    want = expected_tokens.pop_front();
                    check_field("token_char", want.token_char, out_if.token_char);
                    check_field("has_char", 8'(want.has_char), 8'(out_if.has_char));
                    check_field("ends_token", 8'(want.ends_token), 8'(out_if.ends_token));
                    check_field("new_line", 8'(want.new_line), 8'(out_if.new_line));
                    check_field("last_of_run", 8'(want.last_of_run), 8'(out_if.last_of_run));
                end
                rx_wait = (rx_idle_max > 0) ? $urandom_range(0, rx_idle_max) : 0;
            end
            // a long hold-off asked for by the stimulus, counted here
            if (holds_done != hold_reqs) begin
                holds_done++;
                rx_wait = LONG_HOLD;
            end
            if (rx_wait > 0) begin
                rx_wait--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // watchdog: ends the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("FAILURE");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // wait until every byte is taken and every result is back, then let the block settle
    task automatic wait_drained();
        do @(negedge i_clk);
        while (script_bytes.size() != 0 || in_if.valid || expected_tokens.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // block is idle here, so the predictor copy can follow the writes directly
    task automatic set_modes(logic fn, logic cs);
        write_reg(sct_pkg::CFG_FILENAME_MODE, fn);
        write_reg(sct_pkg::CFG_COMMA_SEP, cs);
        fname_mode = fn;
        comma_sep  = cs;
        @(negedge i_clk);
    endtask

    task automatic run_phase(logic fn, logic cs, int tx_max, int rx_max, bit long_hold);
        wait_drained();
        set_modes(fn, cs);
        tx_idle_max = tx_max;
        rx_idle_max = rx_max;
        for (int k = 0; k < PHASE_ITEMS; k++)
            script_bytes.push_back(pick_script_byte(10));
        // receiver stalls while the sender keeps going, so the block backs up
        if (long_hold)
            hold_reqs <= hold_reqs + 1;
    endtask

    initial begin
        logic [7:0] directed[$];
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = sct_pkg::CFG_FILENAME_MODE;
        i_cfg_data    = 1'b0;
        in_if.valid   = 1'b0;
        in_if.in_char = 8'h00;
        out_if.ready  = 1'b0;
        fname_mode    = 1'b0;
        comma_sep     = 1'b0;
        in_token      = 1'b0;
        tx_idle_max   = 3;
        rx_idle_max   = 3;
        hold_reqs     = 0;
        holds_done    = 0;
        errors        = 0;
        stall_cycles  = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        set_modes(1'b0, 1'b0);

        // directed: string end and control bytes inside and between tokens, all
        // separators and operators, braces opening and splitting tokens, field extremes
        directed = '{"a", sct_pkg::CH_NUL, 8'h01, "b", 8'hff, sct_pkg::CH_TILDE, "!",
                     sct_pkg::CH_SPACE, sct_pkg::CH_SPACE, "x", sct_pkg::CH_SLASH,
                     sct_pkg::CH_MINUS, sct_pkg::CH_LBRACE, sct_pkg::CH_RBRACE,
                     sct_pkg::CH_TAB, sct_pkg::CH_SQUOTE, "q", sct_pkg::CH_DQUOTE,
                     sct_pkg::CH_LPAREN, "z", sct_pkg::CH_COMMA, sct_pkg::CH_RPAREN,
                     sct_pkg::CH_PLUS, sct_pkg::CH_STAR, 8'h7f};
        foreach (directed[k])
            script_bytes.push_back(directed[k]);

        // random phases over every mode setting and idling pattern
        run_phase(1'b0, 1'b0, 5, 5, 1'b0);
        run_phase(1'b1, 1'b0, 5, 0, 1'b0);
        run_phase(1'b0, 1'b1, 0, 5, 1'b0);
        run_phase(1'b1, 1'b1, 5, 5, 1'b0);
        run_phase(1'b0, 1'b0, 0, 0, 1'b1);
        run_phase(1'b1, 1'b1, 0, 0, 1'b0);
        for (int p = 0; p < 4; p++)
            run_phase(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      $urandom_range(0, 1) * 5, $urandom_range(0, 1) * 5, 1'b0);

        wait_drained();
        if (errors == 0 && expected_tokens.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
